@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication into the next cycle, checked also while reset is applied.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// Implication into the next cycle, ignored while reset is applied.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication within the same cycle, ignored while reset is applied.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/fbmc_pkg.sv @@
// Types and constants of the fader and button controller scanner.
package fbmc_pkg;

  localparam int HW_CHANNELS = 4;
  localparam int NUM_REGS    = 2 * HW_CHANNELS;
  localparam int MSG_SLOTS   = 2 * HW_CHANNELS;
  localparam int CFG_INDEX_W = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] PRESS_VALUE   = 7'd127;
  localparam logic [6:0] RELEASE_VALUE = 7'd0;
  localparam logic [7:0] LEVEL_RESET   = 8'hFF;
  localparam logic [HW_CHANNELS-1:0] BUTTON_RESET = '1;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_FADER0_CTRL  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FADER1_CTRL  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FADER2_CTRL  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FADER3_CTRL  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON0_CTRL = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON1_CTRL = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON2_CTRL = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON3_CTRL = 4'd7;

  // Entry i is the reset controller number of register i.
  localparam logic [NUM_REGS-1:0][6:0] CTRL_RESET = {
    7'd23, 7'd22, 7'd21, 7'd20, 7'd10, 7'd9, 7'd8, 7'd7
  };

  typedef struct packed {
    logic [11:0] fader0_sample;
    logic [11:0] fader1_sample;
    logic [11:0] fader2_sample;
    logic [11:0] fader3_sample;
    logic [3:0]  button_bits;
  } scan_t;

  typedef struct packed {
    logic [6:0] controller_number;
    logic [6:0] controller_value;
    logic       last_of_run;
  } msg_t;

  // Controller numbers: slots 0 to 3 faders, 4 to 7 buttons.
  typedef struct packed {
    logic [NUM_REGS-1:0][6:0] number;
  } ctrl_t;

  // One classified scan waiting for the back end.
  typedef struct packed {
    logic [HW_CHANNELS-1:0][6:0]  level;
    logic [HW_CHANNELS-1:0]       pressed;
    logic [MSG_SLOTS-1:0]         change;
  } work_t;

endpackage

@@ rtl/fader_button_midi_cc_scanner.sv @@
// Top level of the fader and button controller change scanner.
//
//   port group      role        transfer when
//   push/full/scan  scan in     push && !full
//   empty/pop/msg   message out pop && !empty
//   cfg_*           reg write   cfg_valid && cfg_ready (ready is always high)
//
// A scan is taken whenever the two-entry scan queue has room. The message
// unit sends one message a cycle while the receiver keeps popping, one for
// each change of a scan; a message passes through the scan queue and the
// output register after its scan is taken. Reset is synchronous and leaves the block ready at once.
// A held message stalls the message unit only; scans keep entering until the
// queue is full.
module fader_button_midi_cc_scanner #(
  parameter int CHANNEL_COUNT = 4,
  parameter int SAMPLE_SHIFT  = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  fbmc_pkg::scan_t                  scan,
  output logic                             empty,
  input  logic                             pop,
  output fbmc_pkg::msg_t                   msg,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [6:0]                       cfg_data
);
  import fbmc_pkg::*;

  ctrl_t ctrl;
  work_t work;
  work_t head;
  logic  work_push;
  logic  head_done;
  logic  q_empty;
  logic  q_full;

  assign full = q_full;

  fbmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl)
  );

  fbmc_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_SHIFT  (SAMPLE_SHIFT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (push && !q_full),
    .scan      (scan),
    .work_push (work_push),
    .work      (work)
  );

  fbmc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (work_push),
    .wr_data (work),
    .rd      (head_done),
    .rd_data (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  fbmc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .head       (head),
    .head_valid (!q_empty),
    .head_done  (head_done),
    .pop        (pop),
    .empty      (empty),
    .msg        (msg)
  );

endmodule

@@ rtl/fbmc_cfg.sv @@
// Controller number registers behind the configuration write port.
module fbmc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [6:0]                       cfg_data,
  output fbmc_pkg::ctrl_t                  ctrl
);
  import fbmc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.number <= CTRL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FADER0_CTRL:  ctrl.number[0] <= cfg_data;
        REG_FADER1_CTRL:  ctrl.number[1] <= cfg_data;
        REG_FADER2_CTRL:  ctrl.number[2] <= cfg_data;
        REG_FADER3_CTRL:  ctrl.number[3] <= cfg_data;
        REG_BUTTON0_CTRL: ctrl.number[4] <= cfg_data;
        REG_BUTTON1_CTRL: ctrl.number[5] <= cfg_data;
        REG_BUTTON2_CTRL: ctrl.number[6] <= cfg_data;
        REG_BUTTON3_CTRL: ctrl.number[7] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/fbmc_front.sv @@
// Front end: takes a scan, compares it with the stored state and flags changes.
module fbmc_front #(
  parameter int CHANNEL_COUNT = 4,
  parameter int SAMPLE_SHIFT  = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  fbmc_pkg::scan_t scan,
  output logic            work_push,
  output fbmc_pkg::work_t work
);
  import fbmc_pkg::*;

  localparam int ACTIVE = (CHANNEL_COUNT < HW_CHANNELS) ? CHANNEL_COUNT : HW_CHANNELS;

  logic [HW_CHANNELS-1:0][7:0]  prev_level;
  logic [HW_CHANNELS-1:0]       prev_buttons;
  logic [HW_CHANNELS-1:0][11:0] sample;

  assign sample[0] = scan.fader0_sample;
  assign sample[1] = scan.fader1_sample;
  assign sample[2] = scan.fader2_sample;
  assign sample[3] = scan.fader3_sample;

  always_comb begin
    for (int i = 0; i < HW_CHANNELS; i++) begin
      work.level[i]   = 7'(sample[i] >> SAMPLE_SHIFT);
      work.pressed[i] = scan.button_bits[i];
      work.change[i]  = (i < ACTIVE) && ({1'b0, work.level[i]} != prev_level[i]);
      work.change[HW_CHANNELS + i] =
        (i < ACTIVE) && (scan.button_bits[i] != prev_buttons[i]);
    end
  end

  // A scan with no change leaves nothing for the back end to do.
  assign work_push = accept && (work.change != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HW_CHANNELS; i++) begin
        prev_level[i] <= LEVEL_RESET;
      end
      prev_buttons <= BUTTON_RESET;
    end else if (accept) begin
      for (int i = 0; i < HW_CHANNELS; i++) begin
        if (work.change[i]) begin
          prev_level[i] <= {1'b0, work.level[i]};
        end
      end
      prev_buttons <= scan.button_bits;
    end
  end

endmodule

@@ rtl/fbmc_queue.sv @@
// Two-entry queue of classified scans between the front and back ends.
module fbmc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  fbmc_pkg::work_t wr_data,
  input  logic            rd,
  output fbmc_pkg::work_t rd_data,
  output logic            q_empty,
  output logic            q_full
);
  import fbmc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  work_t                  entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wptr;
  logic [PTR_W-1:0]       rptr;
  logic [PTR_W:0]         count;

  assign q_empty = (count == '0);
  assign q_full  = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(wr) - (PTR_W + 1)'(rd);
    end
  end

endmodule

@@ rtl/fbmc_back.sv @@
// Back end: walks the flagged changes of the oldest scan, one message a cycle while the output is popped.
module fbmc_back (
  input  logic            clk,
  input  logic            rst,
  input  fbmc_pkg::ctrl_t ctrl,
  input  fbmc_pkg::work_t head,
  input  logic            head_valid,
  output logic            head_done,
  input  logic            pop,
  output logic            empty,
  output fbmc_pkg::msg_t  msg
);
  import fbmc_pkg::*;

  localparam int SLOT_W = $clog2(MSG_SLOTS);

  logic [MSG_SLOTS-1:0] sent;
  logic [MSG_SLOTS-1:0] remaining;
  logic [MSG_SLOTS-1:0] pick;
  logic [MSG_SLOTS-1:0] rest;
  logic [SLOT_W-1:0]    slot;
  logic                 out_valid;
  logic                 advance;
  logic                 issue;
  msg_t                 msg_next;

  assign remaining = head.change & ~sent;

  // Lowest pending slot first: faders before buttons, each in index order.
  always_comb begin
    slot = '0;
    for (int i = MSG_SLOTS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        slot = SLOT_W'(i);
      end
    end
    pick = MSG_SLOTS'(1) << slot;
    rest = remaining & ~pick;
  end

  assign advance   = !out_valid || pop;
  assign issue     = head_valid && advance;
  assign head_done = issue && (rest == '0);

  always_comb begin
    msg_next.controller_number = ctrl.number[slot];
    if (slot[SLOT_W-1]) begin
      msg_next.controller_value = head.pressed[slot[SLOT_W-2:0]] ? PRESS_VALUE
                                                                  : RELEASE_VALUE;
    end else begin
      msg_next.controller_value = head.level[slot[SLOT_W-2:0]];
    end
    msg_next.last_of_run = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= '0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
        sent      <= head_done ? '0 : (sent | pick);
      end else if (advance) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      msg <= msg_next;
    end
  end

  assign empty = !out_valid;

endmodule

@@ rtl/fbmc_checker.sv @@
// Port-level checks of the scanner, bound to its top level.
`include "assert_macros.svh"

module fbmc_checker (
  input logic           clk,
  input logic           rst,
  input logic           push,
  input logic           full,
  input logic           empty,
  input logic           pop,
  input fbmc_pkg::msg_t msg,
  input logic           cfg_ready
);
  import fbmc_pkg::*;

  // Reset leaves no message pending and the scan side open.
  `ASSERT_NEXT_ALWAYS(a_reset_clear, clk, rst, empty && !full, "reset did not clear")

  // A message that is not taken stays on the ports unchanged.
  `ASSERT_NEXT(a_msg_hold, clk, rst, !empty && !pop, !empty && $stable(msg), "message changed")

  // With two scans queued the message unit must already be presenting one.
  `ASSERT_NOW(a_full_busy, clk, rst, full, !empty, "queue full while output idle")

  // Configuration writes are never refused.
  `ASSERT_NOW(a_cfg_ready, clk, rst, push || !push, cfg_ready, "config port stalled")

endmodule

bind fader_button_midi_cc_scanner fbmc_checker u_fbmc_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .msg       (msg),
  .cfg_ready (cfg_ready)
);

@@ tb/sv/tb.sv @@
// Self-checking testbench for the fader and button controller change scanner.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbmc_pkg::*;

  localparam int CHANNEL_COUNT = 4;
  localparam int SAMPLE_SHIFT  = 5;
  localparam int ACTIVE_CHANS  = CHANNEL_COUNT < HW_CHANNELS ? CHANNEL_COUNT : HW_CHANNELS;
  localparam logic [11:0] SHIFTED_OUT = 12'((1 << SAMPLE_SHIFT) - 1);
  localparam int DRAIN_CYCLES  = 4 * MSG_SLOTS;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [CFG_INDEX_W-1:0] REG_ORDER [NUM_REGS] = '{
    REG_FADER0_CTRL, REG_FADER1_CTRL, REG_FADER2_CTRL, REG_FADER3_CTRL,
    REG_BUTTON0_CTRL, REG_BUTTON1_CTRL, REG_BUTTON2_CTRL, REG_BUTTON3_CTRL
  };

  class cc_scoreboard;
    logic [6:0]             ctrl_num [NUM_REGS];
    logic [7:0]             fader_level [HW_CHANNELS];
    logic [HW_CHANNELS-1:0] buttons;
    msg_t                   due [$];
    int                     errors;

    function new();
      for (int i = 0; i < NUM_REGS; i++) ctrl_num[i] = CTRL_RESET[i];
      for (int i = 0; i < HW_CHANNELS; i++) fader_level[i] = LEVEL_RESET;
      buttons = BUTTON_RESET;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [6:0] data);
      if (idx < NUM_REGS) ctrl_num[idx] = data;
    endfunction

    // Works out the messages that one accepted scan request gives rise to.
    function void note_scan(scan_t s);
      logic [11:0] smp [HW_CHANNELS];
      logic [6:0]  lvl;
      msg_t        m;
      msg_t        run [$];
      smp = '{s.fader0_sample, s.fader1_sample, s.fader2_sample, s.fader3_sample};
      for (int i = 0; i < ACTIVE_CHANS; i++) begin
        lvl = 7'(smp[i] >> SAMPLE_SHIFT);
        if ({1'b0, lvl} != fader_level[i]) begin
          m = '{ctrl_num[i], lvl, 1'b0};
          run.push_back(m);
          fader_level[i] = {1'b0, lvl};
        end
      end
      for (int i = 0; i < ACTIVE_CHANS; i++) begin
        if (s.button_bits[i] && !buttons[i]) begin
          m = '{ctrl_num[HW_CHANNELS + i], PRESS_VALUE, 1'b0};
          run.push_back(m);
        end else if (!s.button_bits[i] && buttons[i]) begin
          m = '{ctrl_num[HW_CHANNELS + i], RELEASE_VALUE, 1'b0};
          run.push_back(m);
        end
      end
      buttons = s.button_bits;
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) due.push_back(run[i]);
    endfunction

    function void check_msg(msg_t got);
      msg_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected message: number=%0d value=%0d last=%0b", $time,
                 got.controller_number, got.controller_value, got.last_of_run);
        return;
      end
      want = due.pop_front();
      if (got.controller_number !== want.controller_number ||
          got.controller_value !== want.controller_value ||
          got.last_of_run !== want.last_of_run) begin
        errors++;
        $display({"%0t: message differs: expected number=%0d value=%0d last=%0b,",
                  " got number=%0d value=%0d last=%0b"},
                 $time, want.controller_number, want.controller_value, want.last_of_run,
                 got.controller_number, got.controller_value, got.last_of_run);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  scan_t                  scan;
  logic                   empty;
  logic                   pop;
  msg_t                   msg;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [6:0]             cfg_data;

  cc_scoreboard sb = new();
  bit           idling;
  bit           pressure_req;
  int           cycle_count;
  scan_t        last_scan;

  fader_button_midi_cc_scanner #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_SHIFT  (SAMPLE_SHIFT)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .scan      (scan),
    .empty     (empty),
    .pop       (pop),
    .msg       (msg),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fader_button_midi_cc_scanner: mismatch");
      $finish;
    end
  end

  // Messages on the output were caused by earlier requests, so check before noting.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_msg(msg);
      if (push && !full) sb.note_scan(scan);
    end
  end

  function automatic int idle_cycles();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly small moves around the previous scan, so that unchanged faders occur often.
  function automatic scan_t vary_scan(scan_t prev);
    logic [11:0]            f [HW_CHANNELS];
    logic [HW_CHANNELS-1:0] b;
    int                     r;
    if ($urandom_range(0, 9) == 0) return prev;
    f = '{prev.fader0_sample, prev.fader1_sample, prev.fader2_sample, prev.fader3_sample};
    b = prev.button_bits;
    for (int i = 0; i < HW_CHANNELS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) f[i] = (f[i] & ~SHIFTED_OUT) | (12'($urandom) & SHIFTED_OUT);
      else if (r < 55) f[i] = r[0] ? 12'hFFF : 12'h000;
      else f[i] = 12'($urandom);
      if ($urandom_range(0, 9) < 3) b[i] = ~b[i];
    end
    return '{f[0], f[1], f[2], f[3], b};
  endfunction

  initial begin : receiver
    int stall;
    stall = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_req) begin
        pressure_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = idle_cycles();
      end
    end
  end

  task automatic send_scan(input scan_t s);
    int gap;
    @(negedge clk);
    push <= 1'b1;
    scan <= s;
    do @(posedge clk); while (full);
    gap = idle_cycles();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    push <= 1'b0;
  endtask

  task automatic send_random(input int n);
    repeat (n) begin
      last_scan = vary_scan(last_scan);
      send_scan(last_scan);
    end
    stop_sending();
  endtask

  // A scan without changes gives no message and is dropped by the front end.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [6:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic program_controllers(input logic [6:0] nums [NUM_REGS], input bit stray);
    for (int i = 0; i < NUM_REGS; i++) put_reg(REG_ORDER[i], nums[i]);
    // Indexes past the last register must leave every controller number alone.
    if (stray) begin
      for (int k = 0; k < NUM_REGS; k++) put_reg(CFG_INDEX_W'(NUM_REGS + k), 7'($urandom));
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : main
    logic [6:0] nums [NUM_REGS];
    push      = 1'b0;
    scan      = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idling    = 1'b1;
    rst       = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset controller numbers; the first scan reports every fader and every release.
    send_scan(scan_t'{12'h000, 12'h000, 12'h000, 12'h000, 4'b0000});
    send_scan(scan_t'{12'h000, 12'h000, 12'h000, 12'h000, 4'b0000});
    send_scan(scan_t'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 4'b1111});
    send_scan(scan_t'{12'hFE0, 12'hFE1, 12'hFFE, 12'hFEF, 4'b1111});
    send_scan(scan_t'{12'h01F, 12'hFFF, 12'hFFF, 12'hFFF, 4'b0101});
    send_scan(scan_t'{12'h020, 12'h040, 12'h800, 12'h7E0, 4'b0101});
    send_scan(scan_t'{12'h020, 12'h040, 12'h800, 12'h7E0, 4'b1010});
    send_scan(scan_t'{12'h020, 12'h040, 12'h800, 12'h7E0, 4'b0001});
    send_scan(scan_t'{12'hAAA, 12'h555, 12'h0C3, 12'hF3C, 4'b0010});
    send_scan(scan_t'{12'h555, 12'hAAA, 12'hF3C, 12'h0C3, 4'b0100});
    send_scan(scan_t'{12'h000, 12'hFFF, 12'h000, 12'hFFF, 4'b1000});
    last_scan = scan_t'{12'hFFF, 12'h000, 12'hFFF, 12'h000, 4'b1111};
    send_scan(last_scan);
    stop_sending();
    wait_idle();

    foreach (nums[i]) nums[i] = 7'd0;
    program_controllers(nums, 1'b1);
    send_random(40);
    wait_idle();

    // A stretch without any idling on either side.
    foreach (nums[i]) nums[i] = 7'd127;
    program_controllers(nums, 1'b0);
    idling = 1'b0;
    send_random(40);
    wait_idle();

    // The receiver holds off for a long while so that the scan queue fills.
    foreach (nums[i]) nums[i] = 7'($urandom);
    program_controllers(nums, 1'b1);
    idling = 1'b1;
    pressure_req = 1'b1;
    send_random(40);
    wait_idle();

    foreach (nums[i]) nums[i] = 7'($urandom);
    program_controllers(nums, 1'b0);
    send_random(40);
    wait_idle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("fader_button_midi_cc_scanner: match");
    end else begin
      $display("fader_button_midi_cc_scanner: mismatch");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/fbmc_pkg.sv
rtl/fbmc_cfg.sv
rtl/fbmc_front.sv
rtl/fbmc_queue.sv
rtl/fbmc_back.sv
rtl/fader_button_midi_cc_scanner.sv
rtl/fbmc_checker.sv
tb/sv/tb.sv
